/* design/dsd_pkg.sv */
// Shared types, codes and constants of the decimal seven-segment frame driver.
// Used by dsd_bcd_stage, dsd_emitter and decimal_seven_segment_frame_driver.
package dsd_pkg;

  localparam int VALUE_W    = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BRIGHT_W   = 3;
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = VALUE_W / DD_STAGES;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
  localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
  localparam logic [7:0] BYTE_CTRL_CMD = 8'h88;

  // init prefix: start, data cmd, stop, start, ctrl cmd, stop
  localparam int INIT_SYMS    = 6;
  localparam int POS_DATA_CMD = 1;
  localparam int POS_STOP_A   = 2;
  localparam int POS_CTRL_CMD = 4;
  localparam int POS_STOP_B   = 5;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic                  cmd;
    logic [BRIGHT_W-1:0]   bright;
    logic [BCD_DIGITS-1:0] blank;
    logic [VALUE_W-1:0]    bin;
    logic [BCD_W-1:0]      bcd;
  } item_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [VALUE_W-1:0] pow10(input int p);
    logic [VALUE_W-1:0] r;
    case (p)
      1:       r = 16'd10;
      2:       r = 16'd100;
      3:       r = 16'd1000;
      4:       r = 16'd10000;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

endpackage

/* design/dsd_bcd_stage.sv */
// One pipeline stage of the binary to BCD converter (shift and add-3 steps).
// Depends on dsd_pkg for the item struct.
module dsd_bcd_stage #(
  parameter int STEPS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsd_pkg::item_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dsd_pkg::item_t out_item_o
);

  logic           valid_q;
  dsd_pkg::item_t item_q, item_d;

  always_comb begin
    logic [dsd_pkg::BCD_W-1:0]   bcd_v;
    logic [dsd_pkg::VALUE_W-1:0] bin_v;
    item_d = in_item_i;
    bcd_v  = in_item_i.bcd;
    bin_v  = in_item_i.bin;
    for (int s = 0; s < STEPS; s++) begin
      for (int d = 0; d < dsd_pkg::BCD_DIGITS; d++) begin
        if (bcd_v[4*d +: 4] >= 4'd5) begin
          bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v[dsd_pkg::BCD_W-2:0], bin_v, 1'b0};
    end
    item_d.bcd = bcd_v;
    item_d.bin = bin_v;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* design/dsd_emitter.sv */
// Symbol sequencer: maps digits to segments and plays out one transaction's bus
// frames into an output register, one symbol per cycle unless stalled; uses dsd_pkg.
module dsd_emitter #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dsd_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     symbol_kind_o,
  output logic [7:0]     symbol_byte_o,
  output logic           last_o
);

  localparam int IDX_W    = $clog2(DIGIT_COUNT + dsd_pkg::INIT_SYMS + 3);
  localparam int STOP_POS = DIGIT_COUNT + 2;

  logic                         busy_q;
  logic                         cmd_q;
  logic [dsd_pkg::BRIGHT_W-1:0] bright_q;
  logic [IDX_W-1:0]             idx_q;
  logic [7:0]                   segs_q [DIGIT_COUNT];
  logic [7:0]                   segs_load [DIGIT_COUNT];

  logic                         out_valid_q;
  dsd_pkg::kind_e               kind_q, kind_d;
  logic [7:0]                   byte_q, byte_d;
  logic                         last_q, last_d;

  logic                         advance;
  logic                         done;
  logic                         load;
  logic                         is_seg;
  logic                         in_prefix;
  logic [IDX_W-1:0]             pos;

  always_comb begin
    in_prefix = (cmd_q == dsd_pkg::CMD_INIT) && (idx_q < IDX_W'(dsd_pkg::INIT_SYMS));
    pos       = (cmd_q == dsd_pkg::CMD_INIT) ? idx_q - IDX_W'(dsd_pkg::INIT_SYMS) : idx_q;
    kind_d    = dsd_pkg::KIND_START;
    byte_d    = 8'h00;
    last_d    = 1'b0;
    is_seg    = 1'b0;
    if (in_prefix) begin
      if (idx_q == IDX_W'(dsd_pkg::POS_DATA_CMD)) begin
        kind_d = dsd_pkg::KIND_BYTE;
        byte_d = dsd_pkg::BYTE_DATA_CMD;
      end else if (idx_q == IDX_W'(dsd_pkg::POS_CTRL_CMD)) begin
        kind_d = dsd_pkg::KIND_BYTE;
        byte_d = dsd_pkg::BYTE_CTRL_CMD | {5'd0, bright_q};
      end else if (idx_q == IDX_W'(dsd_pkg::POS_STOP_A) ||
                   idx_q == IDX_W'(dsd_pkg::POS_STOP_B)) begin
        kind_d = dsd_pkg::KIND_STOP;
      end
    end else if (pos == IDX_W'(0)) begin
      kind_d = dsd_pkg::KIND_START;
    end else if (pos == IDX_W'(1)) begin
      kind_d = dsd_pkg::KIND_BYTE;
      byte_d = dsd_pkg::BYTE_ADDR_CMD;
    end else if (pos == IDX_W'(STOP_POS)) begin
      kind_d = dsd_pkg::KIND_STOP;
      last_d = 1'b1;
    end else begin
      kind_d = dsd_pkg::KIND_BYTE;
      byte_d = segs_q[0];
      is_seg = 1'b1;
    end
  end

  // digit i from the left sits at decimal position DIGIT_COUNT-1-i
  always_comb begin
    logic [3:0] digit;
    logic       blank;
    int         p;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      p     = DIGIT_COUNT - 1 - i;
      digit = 4'(in_item_i.bcd >> (4 * p));
      blank = (p != 0) &&
              ((p >= dsd_pkg::BCD_DIGITS) || 1'(in_item_i.blank >> p));
      if (in_item_i.cmd == dsd_pkg::CMD_INIT || blank) begin
        segs_load[i] = 8'h00;
      end else begin
        segs_load[i] = dsd_pkg::seg_of(digit);
      end
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign done       = busy_q && advance && last_d;
  assign in_ready_o = !busy_q || done;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= busy_q;
      end
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end
        if (advance && busy_q) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && busy_q) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
      if (is_seg) begin
        for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
          segs_q[i] <= segs_q[i+1];
        end
        segs_q[DIGIT_COUNT-1] <= 8'h00;
      end
    end
    if (load) begin
      cmd_q    <= in_item_i.cmd;
      bright_q <= in_item_i.bright;
      segs_q   <= segs_load;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_kind_o = kind_q;
  assign symbol_byte_o = byte_q;
  assign last_o        = last_q;

endmodule

/* design/decimal_seven_segment_frame_driver.sv */
// Top level of the decimal seven-segment frame driver: input register, config
// register, BCD pipeline and symbol sequencer. Depends on dsd_pkg, dsd_bcd_stage,
// dsd_emitter.
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+--------------------------
//  in       | in_valid_i, in_ready_o, cmd_i, value_i    | one command transaction
//  out      | out_valid_o, out_ready_i, symbol_kind_o,  | one bus symbol
//           | symbol_byte_o, last_o                     |
//  cfg      | psel, penable, pwrite, paddr, pwdata,     | brightness register
//           | prdata, pready                            |
//
// a show transaction gives DIGIT_COUNT+3 symbols, init gives DIGIT_COUNT+9, one per
// cycle while out is not stalled, from the sequencer's output register; that
// register sets the sustained rate. The first symbol passes the input register,
// the four BCD stages and the sequencer; later transactions queue in the pipeline
// behind it. Reset clears all valid bits and sets brightness to 7; a stall on out
// holds the symbol and backs up the pipeline stage by stage without loss
module decimal_seven_segment_frame_driver #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  symbol_kind_o,
  output logic [7:0]  symbol_byte_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [dsd_pkg::BRIGHT_W-1:0] bright_q;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {29'd0, bright_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= dsd_pkg::BRIGHT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bright_q <= pwdata[dsd_pkg::BRIGHT_W-1:0];
    end
  end

  logic           valid_s [dsd_pkg::DD_STAGES+1];
  logic           ready_s [dsd_pkg::DD_STAGES+1];
  dsd_pkg::item_t item_s  [dsd_pkg::DD_STAGES+1];

  logic           in_valid_q;
  dsd_pkg::item_t in_item_q, in_item_d;

  always_comb begin
    in_item_d        = '0;
    in_item_d.cmd    = cmd_i;
    in_item_d.bright = bright_q;
    in_item_d.bin    = value_i;
    in_item_d.bcd    = '0;
    for (int p = 1; p < dsd_pkg::BCD_DIGITS; p++) begin
      in_item_d.blank[p] = value_i < dsd_pkg::pow10(p);
    end
  end

  assign in_ready_o = !in_valid_q || ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_d;
    end
  end

  assign valid_s[0] = in_valid_q;
  assign item_s[0]  = in_item_q;

  for (genvar g = 0; g < dsd_pkg::DD_STAGES; g++) begin : g_bcd
    dsd_bcd_stage #(
      .STEPS (dsd_pkg::DD_STEPS)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[g]),
      .in_ready_o  (ready_s[g]),
      .in_item_i   (item_s[g]),
      .out_valid_o (valid_s[g+1]),
      .out_ready_i (ready_s[g+1]),
      .out_item_o  (item_s[g+1])
    );
  end

  dsd_emitter #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (valid_s[dsd_pkg::DD_STAGES]),
    .in_ready_o    (ready_s[dsd_pkg::DD_STAGES]),
    .in_item_i     (item_s[dsd_pkg::DD_STAGES]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_kind_o (symbol_kind_o),
    .symbol_byte_o (symbol_byte_o),
    .last_o        (last_o)
  );

endmodule

/* dv/decimal_seven_segment_frame_driver_tb.sv */
// Self-checking testbench for decimal_seven_segment_frame_driver: directed and random
// init/show transactions, brightness writes over APB, bus symbol prediction in the bench.
// Depends on dsd_pkg and the design sources only.
module decimal_seven_segment_frame_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS = 4;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_CAP = 100;
  localparam logic [2:0] BRIGHT_ADDR = 3'd0;
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
  localparam logic [9:0][7:0] SEG_PATTERN = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct {
    logic        cmd;
    logic [15:0] value;
  } cmd_item_t;

  typedef struct {
    dsd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } bus_sym_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = dsd_pkg::CMD_INIT;
  logic [15:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  symbol_kind_o;
  logic [7:0]  symbol_byte_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cmd_item_t   stimulus_q[$];
  bus_sym_t    awaited_syms[$];
  cmd_item_t   next_item;
  bus_sym_t    got_sym;
  logic [2:0]  bright_setting = dsd_pkg::BRIGHT_RESET;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  int unsigned mismatch_count = 0;
  int unsigned init_count = 0;
  int unsigned show_count = 0;
  int unsigned symbols_checked = 0;
  int unsigned bright_writes = 0;

  decimal_seven_segment_frame_driver #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .symbol_kind_o,
    .symbol_byte_o,
    .last_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int exp_val, input int act_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
    end
  endtask

  task automatic push_sym(input dsd_pkg::kind_e kind, input logic [7:0] data);
    bus_sym_t s;
    s.kind = kind;
    s.data = data;
    s.last = 1'b0;
    awaited_syms.push_back(s);
  endtask

  task automatic push_frame(input logic [7:0] data);
    push_sym(dsd_pkg::KIND_START, 8'h00);
    push_sym(dsd_pkg::KIND_BYTE, data);
    push_sym(dsd_pkg::KIND_STOP, 8'h00);
  endtask

  task automatic predict_frames(input logic cmd, input logic [15:0] value);
    logic [DIGITS-1:0][7:0] segs;
    int unsigned pw;
    int unsigned digit;
    segs = '0;
    if (cmd == dsd_pkg::CMD_INIT) begin
      push_frame(dsd_pkg::BYTE_DATA_CMD);
      push_frame(dsd_pkg::BYTE_CTRL_CMD | {5'd0, bright_setting});
    end else begin
      pw = 1;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        digit = (value / pw) % 10;
        segs[i] = SEG_PATTERN[digit];
        if (i < DIGITS - 1 && value < pw) begin
          segs[i] = 8'h00;
        end
        pw = pw * 10;
      end
    end
    push_sym(dsd_pkg::KIND_START, 8'h00);
    push_sym(dsd_pkg::KIND_BYTE, dsd_pkg::BYTE_ADDR_CMD);
    for (int i = 0; i < DIGITS; i++) begin
      push_sym(dsd_pkg::KIND_BYTE, segs[i]);
    end
    push_sym(dsd_pkg::KIND_STOP, 8'h00);
    awaited_syms[awaited_syms.size() - 1].last = 1'b1;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stimulus_q.size() > 0) begin
        next_item = stimulus_q.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= next_item.cmd;
        value_i <= next_item.value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver with its own stall pattern and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rx_cycle <= 0;
      rx_mode <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 50 == 0) begin
        rx_mode <= $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left <= hold_left - 1;
        if (hold_left == 1) begin
          hold_done <= 1'b1;
        end
      end else if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_left <= HOLD_CYCLES;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) == 0);
          2: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // prediction on each accepted command transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (cmd_i == dsd_pkg::CMD_INIT) begin
        init_count++;
      end else begin
        show_count++;
      end
      predict_frames(cmd_i, value_i);
    end
  end

  // symbol checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_syms.size() == 0) begin
        report_mismatch("unexpected symbol, kind", -1, symbol_kind_o);
      end else begin
        got_sym = awaited_syms.pop_front();
        symbols_checked++;
        if (symbol_kind_o !== got_sym.kind) begin
          report_mismatch("symbol_kind", got_sym.kind, symbol_kind_o);
        end
        if (symbol_byte_o !== got_sym.data) begin
          report_mismatch("symbol_byte", got_sym.data, symbol_byte_o);
        end
        if (last_o !== got_sym.last) begin
          report_mismatch("last", got_sym.last, last_o);
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == BRIGHT_ADDR) begin
      bright_setting = data[2:0];
      bright_writes++;
    end
  endtask

  task automatic apb_check_brightness();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= BRIGHT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[2:0] !== bright_setting) begin
      report_mismatch("brightness readback", bright_setting, prdata[2:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_item(input logic cmd, input logic [15:0] value);
    cmd_item_t it;
    it.cmd = cmd;
    it.value = value;
    stimulus_q.push_back(it);
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'($urandom_range(0, 9));
      1: v = 16'($urandom_range(10, 99));
      2: v = 16'($urandom_range(100, 999));
      3: v = 16'($urandom_range(1000, 9999));
      4: v = 16'($urandom_range(10000, 65535));
      5: v = 16'($urandom_range(0, 6) == 0 ? 0 : (10 ** $urandom_range(1, 4)) - 1);
      6: v = 16'($urandom_range(1, 4) == 4 ? 10000 : 10 ** $urandom_range(1, 3));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_random(input int n);
    queue_item(dsd_pkg::CMD_INIT, 16'($urandom));
    for (int i = 1; i < n; i++) begin
      queue_item(($urandom_range(0, 3) == 0) ? dsd_pkg::CMD_INIT : dsd_pkg::CMD_SHOW,
                 pick_value());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (stimulus_q.size() != 0 || in_valid_i || awaited_syms.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    apb_check_brightness();

    queue_item(dsd_pkg::CMD_INIT, 16'h0000);
    queue_item(dsd_pkg::CMD_INIT, 16'hFFFF);
    queue_item(dsd_pkg::CMD_SHOW, 16'd0);
    queue_item(dsd_pkg::CMD_SHOW, 16'd1);
    queue_item(dsd_pkg::CMD_SHOW, 16'd8);
    queue_item(dsd_pkg::CMD_SHOW, 16'd9);
    queue_item(dsd_pkg::CMD_SHOW, 16'd10);
    queue_item(dsd_pkg::CMD_SHOW, 16'd99);
    queue_item(dsd_pkg::CMD_SHOW, 16'd100);
    queue_item(dsd_pkg::CMD_SHOW, 16'd999);
    queue_item(dsd_pkg::CMD_SHOW, 16'd1000);
    queue_item(dsd_pkg::CMD_SHOW, 16'd1234);
    queue_item(dsd_pkg::CMD_SHOW, 16'd9999);
    queue_item(dsd_pkg::CMD_SHOW, 16'd10000);
    queue_item(dsd_pkg::CMD_SHOW, 16'd12345);
    queue_item(dsd_pkg::CMD_SHOW, 16'd50000);
    queue_item(dsd_pkg::CMD_SHOW, 16'd65535);
    queue_item(dsd_pkg::CMD_SHOW, 16'h5555);
    queue_item(dsd_pkg::CMD_SHOW, 16'hAAAA);
    queue_item(dsd_pkg::CMD_SHOW, 16'h8000);
    queue_item(dsd_pkg::CMD_INIT, 16'h1234);
    wait_idle();

    apb_write(BRIGHT_ADDR, 32'h0000_0000);
    apb_check_brightness();
    hold_req <= 1'b1;
    queue_random(35);
    wait_idle();

    apb_write(UNMAPPED_ADDR, 32'h0000_0005);
    apb_check_brightness();
    queue_random(30);
    wait_idle();

    apb_write(BRIGHT_ADDR, 32'hFFFF_FFFF);
    apb_check_brightness();
    queue_random(30);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      apb_write(BRIGHT_ADDR, $urandom);
      apb_check_brightness();
      queue_random(18);
      wait_idle();
    end

    $display("covered %0d init and %0d show transactions, %0d bus symbols checked",
             init_count, show_count, symbols_checked);
    $display("%0d brightness writes incl. 0 and 7, one unmapped write, one long output hold-off",
             bright_writes);
    if (mismatch_count == 0 && awaited_syms.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/dsd_pkg.sv
design/dsd_bcd_stage.sv
design/dsd_emitter.sv
design/decimal_seven_segment_frame_driver.sv
dv/decimal_seven_segment_frame_driver_tb.sv
